/* sv/qsac_pkg.sv */
package qsac_pkg;

  // Geometry and storage
  localparam int COORD_BITS = 16;
  localparam int CORNERS    = 4;
  localparam int NUM_PTS    = 2 * CORNERS;
  localparam int IDX_W      = $clog2(NUM_PTS);
  localparam int CRN_W      = $clog2(CORNERS);

  // Microprogram step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_RD_A   = 3'd1;
  localparam logic [PC_W-1:0] PC_RD_B   = 3'd2;
  localparam logic [PC_W-1:0] PC_AXIS   = 3'd3;
  localparam logic [PC_W-1:0] PC_PROJ   = 3'd4;
  localparam logic [PC_W-1:0] PC_DRAIN0 = 3'd5;
  localparam logic [PC_W-1:0] PC_DRAIN1 = 3'd6;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd7;

  // Corner store read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_EDGE_A,
    RD_EDGE_B,
    RD_CORNER
  } rd_sel_e;

  // Branch kinds
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_START,
    BR_LOOP,
    BR_TEST
  } br_e;

  typedef struct packed {
    rd_sel_e         rd_sel;
    logic            ld_pa;
    logic            ld_axis;
    logic            issue;
    br_e             br;
    logic [PC_W-1:0] target;
  } uc_word_t;

  // Sequencer to datapath
  typedef struct packed {
    logic [IDX_W-1:0] raddr;
    logic             ld_pa;
    logic             ld_axis;
    logic             issue;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic sep;
  } stat_t;

  // Control store: rd_sel, ld_pa, ld_axis, issue, br, target
  localparam uc_word_t UCODE [1 << PC_W] = '{
    '{RD_NONE,   1'b0, 1'b0, 1'b0, BR_START, PC_RD_A},  // idle, wait for a check
    '{RD_EDGE_A, 1'b0, 1'b0, 1'b0, BR_NEXT,  PC_RD_B},  // fetch edge start corner
    '{RD_EDGE_B, 1'b1, 1'b0, 1'b0, BR_NEXT,  PC_AXIS},  // fetch edge end corner
    '{RD_NONE,   1'b0, 1'b1, 1'b0, BR_NEXT,  PC_PROJ},  // form normal axis
    '{RD_CORNER, 1'b0, 1'b0, 1'b1, BR_LOOP,  PC_PROJ},  // stream all corners
    '{RD_NONE,   1'b0, 1'b0, 1'b0, BR_NEXT,  PC_DRAIN1},
    '{RD_NONE,   1'b0, 1'b0, 1'b0, BR_NEXT,  PC_TEST},
    '{RD_NONE,   1'b0, 1'b0, 1'b0, BR_TEST,  PC_RD_A}   // compare intervals
  };

endpackage

/* sv/quad_separating_axis_collision_core.sv */
// A corner write without check leaves the sequencer idle; a new transaction is taken the next cycle.
// A check walks up to eight axes, each by two corner reads, axis build, eight pipelined
// projections through the one store read port, drain and compare, to a registered result;
// a separating axis ends the walk early, and an earlier result still stalled at the output
// holds each compare step until it leaves.
// Reset clears the sequencer, output register and projection tags; corner storage holds no reset value.
module quad_separating_axis_collision_core #(
  parameter int COORD_BITS = qsac_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         shape_i,
  input  logic [1:0]                   corner_i,
  input  logic signed [COORD_BITS-1:0] sprite_x_i,
  input  logic signed [COORD_BITS-1:0] sprite_y_i,
  input  logic signed [COORD_BITS-1:0] offset_x_i,
  input  logic signed [COORD_BITS-1:0] offset_y_i,
  input  logic                         check_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         collide_o
);
  import qsac_pkg::*;

  logic  accept;
  logic  busy;
  ctrl_t ctrl;
  stat_t stat;

  // Take a transaction only while the sequencer sits idle
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  qsac_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && check_i),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .collide_o  (collide_o)
  );

  qsac_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept),
    .waddr_i   ({shape_i, corner_i}),
    .sprite_x_i(sprite_x_i),
    .sprite_y_i(sprite_y_i),
    .offset_x_i(offset_x_i),
    .offset_y_i(offset_y_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat)
  );

endmodule

/* sv/qsac_ram.sv */
module qsac_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/qsac_dp.sv */
module qsac_dp #(
  parameter int COORD_BITS = qsac_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [qsac_pkg::IDX_W-1:0]   waddr_i,
  input  logic signed [COORD_BITS-1:0] sprite_x_i,
  input  logic signed [COORD_BITS-1:0] sprite_y_i,
  input  logic signed [COORD_BITS-1:0] offset_x_i,
  input  logic signed [COORD_BITS-1:0] offset_y_i,
  input  qsac_pkg::ctrl_t              ctrl_i,
  output qsac_pkg::stat_t              stat_o
);
  import qsac_pkg::*;

  localparam int PW  = COORD_BITS + 1;  // stored corner coordinate
  localparam int AW  = COORD_BITS + 2;  // axis component
  localparam int PRW = PW + AW;         // one product
  localparam int PJ  = PRW + 1;         // projection

  typedef struct packed {
    logic vld;
    logic shape;
    logic first;
  } tag_t;

  logic signed [PW-1:0]  wx, wy, rx, ry;
  logic [2*PW-1:0]       rdata;
  logic signed [PW-1:0]  pax_q, pay_q;
  logic signed [AW-1:0]  ax_q, ay_q;
  logic signed [PRW-1:0] mx_d, my_d, mx_q, my_q;
  logic signed [PJ-1:0]  proj;
  logic signed [PJ-1:0]  lo_q [2];
  logic signed [PJ-1:0]  hi_q [2];
  tag_t                  tag_d, tag_r_q, tag_m_q;

  // Corner sum, exact at one extra bit
  assign wx = PW'(sprite_x_i) + PW'(offset_x_i);
  assign wy = PW'(sprite_y_i) + PW'(offset_y_i);

  qsac_ram #(
    .WIDTH(2 * PW),
    .DEPTH(NUM_PTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i({wx, wy}),
    .raddr_i(ctrl_i.raddr),
    .rdata_o(rdata)
  );

  assign rx = rdata[2*PW-1:PW];
  assign ry = rdata[PW-1:0];

  // Latch edge start corner, then form the normal (-dy, dx)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_pa) begin
      pax_q <= rx;
      pay_q <= ry;
    end
    if (ctrl_i.ld_axis) begin
      ax_q <= AW'(pay_q) - AW'(ry);
      ay_q <= AW'(rx) - AW'(pax_q);
    end
  end

  // Track each projection through read and multiply stages
  assign tag_d.vld   = ctrl_i.issue;
  assign tag_d.shape = ctrl_i.raddr[IDX_W-1];
  assign tag_d.first = (ctrl_i.raddr[CRN_W-1:0] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_r_q <= '0;
      tag_m_q <= '0;
    end else begin
      tag_r_q <= tag_d;
      tag_m_q <= tag_r_q;
    end
  end

  // Multiply stage
  assign mx_d = PRW'(rx) * PRW'(ax_q);
  assign my_d = PRW'(ry) * PRW'(ay_q);

  always_ff @(posedge clk_i) begin
    if (tag_r_q.vld) begin
      mx_q <= mx_d;
      my_q <= my_d;
    end
  end

  // Sum and fold into the per-shape interval
  assign proj = PJ'(mx_q) + PJ'(my_q);

  always_ff @(posedge clk_i) begin
    if (tag_m_q.vld) begin
      if (tag_m_q.first) begin
        lo_q[tag_m_q.shape] <= proj;
        hi_q[tag_m_q.shape] <= proj;
      end else begin
        if (proj < lo_q[tag_m_q.shape]) begin
          lo_q[tag_m_q.shape] <= proj;
        end
        if (proj > hi_q[tag_m_q.shape]) begin
          hi_q[tag_m_q.shape] <= proj;
        end
      end
    end
  end

  // Strict gap separates; touching does not
  assign stat_o.sep = (hi_q[0] < lo_q[1]) || (hi_q[1] < lo_q[0]);

endmodule

/* sv/qsac_seq.sv */
module qsac_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_stall_i,
  input  qsac_pkg::stat_t stat_i,
  output qsac_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            out_valid_o,
  output logic            collide_o
);
  import qsac_pkg::*;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IDX_W-1:0] axis_q, axis_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             collide_q, collide_d;
  uc_word_t         uw;
  logic [CRN_W-1:0] edge_end;

  assign uw       = UCODE[pc_q];
  assign edge_end = axis_q[CRN_W-1:0] + CRN_W'(1);

  // Decode the read address and strobes for this step
  always_comb begin
    ctrl_o.ld_pa   = uw.ld_pa;
    ctrl_o.ld_axis = uw.ld_axis;
    ctrl_o.issue   = uw.issue;
    case (uw.rd_sel)
      RD_EDGE_A: ctrl_o.raddr = axis_q;
      RD_EDGE_B: ctrl_o.raddr = {axis_q[IDX_W-1], edge_end};
      RD_CORNER: ctrl_o.raddr = cnt_q;
      default:   ctrl_o.raddr = '0;
    endcase
  end

  // Advance the step counter and the loop counters
  always_comb begin
    pc_d        = pc_q + PC_W'(1);
    axis_d      = axis_q;
    cnt_d       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    collide_d   = collide_q;
    case (uw.br)
      BR_START: begin
        pc_d   = start_i ? uw.target : pc_q;
        axis_d = '0;
      end
      BR_LOOP: begin
        cnt_d = cnt_q + IDX_W'(1);
        pc_d  = (cnt_q == IDX_W'(NUM_PTS - 1)) ? pc_q + PC_W'(1) : uw.target;
      end
      BR_TEST: begin
        if (out_valid_q && out_stall_i) begin
          pc_d = pc_q;
        end else if (stat_i.sep || axis_q == IDX_W'(NUM_PTS - 1)) begin
          pc_d        = PC_IDLE;
          out_valid_d = 1'b1;
          collide_d   = !stat_i.sep;
        end else begin
          pc_d   = uw.target;
          axis_d = axis_q + IDX_W'(1);
        end
      end
      default: begin
        pc_d = uw.target;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      axis_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      collide_q   <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      collide_q   <= collide_d;
    end
  end

  assign busy_o      = (pc_q != PC_IDLE);
  assign out_valid_o = out_valid_q;
  assign collide_o   = collide_q;

endmodule
